### design/bad_pkg.sv
// ----------------------------------------------------------------------------
// Block average downscaler package
// Payload types of the pixel and result channels and the fixed widths and
// constants shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package bad_pkg;

   localparam int PIXEL_W     = 8;
   localparam int COORD_W     = 5;
   // Fixed-point shift of the reciprocal used to divide a block sum.
   localparam int RECIP_SHIFT = 24;
   // Result queue depth and its pointer width.
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_W       = 2;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               start_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] avg_pixel;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic               frame_last;
   } rsp_payload_type;

endpackage

### design/bad_req_if.sv
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel that carries one input pixel per transaction.
// ----------------------------------------------------------------------------
interface bad_req_if;
   import bad_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### design/bad_rsp_if.sv
// ----------------------------------------------------------------------------
// Averaged pixel response channel
// Valid/ready channel that carries one averaged pixel per transaction.
// ----------------------------------------------------------------------------
interface bad_rsp_if;
   import bad_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### design/bad_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bad_ram #(
   parameter int WIDTH  = 14,
   parameter int DEPTH  = 28,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/block_average_downscaler_core.sv
// ----------------------------------------------------------------------------
// Block average downscaler core
// Averages non-overlapping BLOCK x BLOCK squares of a raster-order grayscale
// frame and emits one averaged pixel per square.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on req_ch in raster order, one per transaction; a frame is
// BLOCK*OUT_WIDTH pixels wide and BLOCK*OUT_HEIGHT high. A set start_of_frame
// flag makes that pixel the top-left of a new frame. When the bottom-right
// pixel of a square arrives, the block mean (truncated) leaves on rsp_ch with
// its output row and column and a frame_last mark on the final one.
// Throughput is one pixel per clock unless the result queue holds off input:
// the partial sums live in a RAM with one entry per column block, read when a
// pixel is accepted and written back in the cycle after; a pixel that hits the
// entry still being updated takes the sum from the pipeline instead of the RAM.
// A completing pixel's result passes the RAM read, the sum update and the
// divide into the queue before it appears on rsp_ch.
// Results wait in a four-deep queue. When rsp_ch stalls, req_ch.ready drops
// only once the queue plus results still in the pipeline would fill it.
// Reset clears the position counters, the pipeline and the queue. The sum RAM
// is not cleared: the first pixel of every square loads its entry.
// ----------------------------------------------------------------------------
module block_average_downscaler_core #(
   parameter int BLOCK      = 5,
   parameter int OUT_WIDTH  = 28,
   parameter int OUT_HEIGHT = 28
) (
   input logic clock,
   input logic reset,
   bad_req_if.sink   req_ch,
   bad_rsp_if.source rsp_ch
);
   import bad_pkg::*;

   localparam int DIV     = BLOCK * BLOCK;
   localparam int SUM_W   = $clog2(DIV * 255 + 1);
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int RECIP   = ((1 << RECIP_SHIFT) + DIV - 1) / DIV;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int IDX_W   = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
   localparam int ROW_W   = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
   localparam int CIB_W   = (BLOCK > 1) ? $clog2(BLOCK) : 1;

   // Control carried along with a pixel through the update pipeline.
   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic               first;
      logic               emit;
      logic               last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } stage_ctrl_type;

   // Raster position counters.
   logic [CIB_W-1:0] col_in_block_ff, col_in_block_in;
   logic [IDX_W-1:0] block_col_ff, block_col_in;
   logic [CIB_W-1:0] row_in_block_ff, row_in_block_in;
   logic [ROW_W-1:0] block_row_ff, block_row_in;

   // Position of the pixel being offered, after start of frame is applied.
   logic [CIB_W-1:0] cur_cib, cur_rib;
   logic [IDX_W-1:0] cur_bcol;
   logic [ROW_W-1:0] cur_brow;
   logic             accept;
   stage_ctrl_type   cur_ctrl;

   // Stage 1: RAM read in flight.
   logic               s1_valid_ff;
   stage_ctrl_type     s1_ctrl_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic               s1_fwd_ff;
   logic               s1_fwd_in;

   // Stage 2: updated sum, waiting to be divided.
   logic           s2_valid_ff;
   stage_ctrl_type s2_ctrl_ff;
   logic [SUM_W-1:0] s2_sum_ff;

   logic [SUM_W-1:0]  ram_rd_data;
   logic [SUM_W-1:0]  sum_base;
   logic [SUM_W-1:0]  sum_new;
   logic [PROD_W-1:0] quot_prod;

   // Result queue.
   rsp_payload_type fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;
   logic [PTR_W:0]   busy;
   logic             push, pop;
   rsp_payload_type  push_data;

   // ------------------------------------------------------------------------
   // Position tracking. A start of frame restarts the counters at this pixel.
   // ------------------------------------------------------------------------
   assign accept   = req_ch.valid && req_ch.ready;
   assign cur_cib  = req_ch.payload.start_of_frame ? '0 : col_in_block_ff;
   assign cur_rib  = req_ch.payload.start_of_frame ? '0 : row_in_block_ff;
   assign cur_bcol = req_ch.payload.start_of_frame ? '0 : block_col_ff;
   assign cur_brow = req_ch.payload.start_of_frame ? '0 : block_row_ff;

   always_comb begin
      cur_ctrl.idx   = cur_bcol;
      cur_ctrl.first = (cur_cib == '0) && (cur_rib == '0);
      cur_ctrl.emit  = (cur_cib == CIB_W'(BLOCK - 1)) && (cur_rib == CIB_W'(BLOCK - 1));
      cur_ctrl.last  = cur_ctrl.emit && (cur_brow == ROW_W'(OUT_HEIGHT - 1)) &&
                       (cur_bcol == IDX_W'(OUT_WIDTH - 1));
      cur_ctrl.row   = COORD_W'(cur_brow);
      cur_ctrl.col   = COORD_W'(cur_bcol);
   end

   // Advance the raster position: column in block, column block, row in
   // block, row block, each wrapping into the next.
   always_comb begin
      col_in_block_in = cur_cib;
      block_col_in    = cur_bcol;
      row_in_block_in = cur_rib;
      block_row_in    = cur_brow;
      if (cur_cib == CIB_W'(BLOCK - 1)) begin
         col_in_block_in = '0;
         if (cur_bcol == IDX_W'(OUT_WIDTH - 1)) begin
            block_col_in = '0;
            if (cur_rib == CIB_W'(BLOCK - 1)) begin
               row_in_block_in = '0;
               if (cur_brow == ROW_W'(OUT_HEIGHT - 1)) begin
                  block_row_in = '0;
               end else begin
                  block_row_in = cur_brow + 1'b1;
               end
            end else begin
               row_in_block_in = cur_rib + 1'b1;
            end
         end else begin
            block_col_in = cur_bcol + 1'b1;
         end
      end else begin
         col_in_block_in = cur_cib + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_in_block_ff <= '0;
         block_col_ff    <= '0;
         row_in_block_ff <= '0;
         block_row_ff    <= '0;
      end else if (accept) begin
         col_in_block_ff <= col_in_block_in;
         block_col_ff    <= block_col_in;
         row_in_block_ff <= row_in_block_in;
         block_row_ff    <= block_row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Sum RAM with read-modify-write. A pixel that follows directly on the
   // same column block would read the entry before stage 1 has written it,
   // so it is marked to take the sum held in stage 2 instead.
   // ------------------------------------------------------------------------
   assign s1_fwd_in = s1_valid_ff && (s1_ctrl_ff.idx == cur_ctrl.idx);

   bad_ram #(
      .WIDTH (SUM_W),
      .DEPTH (OUT_WIDTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ctrl_ff.idx),
      .wr_data (sum_new),
      .rd_en   (accept),
      .rd_addr (cur_ctrl.idx),
      .rd_data (ram_rd_data)
   );

   assign sum_base = s1_fwd_ff ? s2_sum_ff : ram_rd_data;
   assign sum_new  = s1_ctrl_ff.first ? SUM_W'(s1_pix_ff) : sum_base + SUM_W'(s1_pix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= cur_ctrl;
         s1_pix_ff  <= req_ch.payload.pixel;
         s1_fwd_ff  <= s1_fwd_in;
      end
      if (s1_valid_ff) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_sum_ff  <= sum_new;
      end
   end

   // ------------------------------------------------------------------------
   // Divide by BLOCK*BLOCK through a rounded-up reciprocal. A block sum stays
   // small enough that the truncated product equals the true quotient.
   // ------------------------------------------------------------------------
   assign quot_prod = PROD_W'(s2_sum_ff) * PROD_W'(RECIP);

   always_comb begin
      push_data.avg_pixel  = quot_prod[RECIP_SHIFT +: PIXEL_W];
      push_data.out_row    = s2_ctrl_ff.row;
      push_data.out_col    = s2_ctrl_ff.col;
      push_data.frame_last = s2_ctrl_ff.last;
   end

   // ------------------------------------------------------------------------
   // Result queue. Input is held off when the queue could not take every
   // result already in the pipeline plus one from a new pixel.
   // ------------------------------------------------------------------------
   assign push     = s2_valid_ff && s2_ctrl_ff.emit;
   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign count_in = count_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   assign busy     = count_ff + (PTR_W + 1)'(s1_valid_ff && s1_ctrl_ff.emit) +
                     (PTR_W + 1)'(push);

   assign req_ch.ready   = busy < (PTR_W + 1)'(FIFO_DEPTH);
   assign rsp_ch.valid   = count_ff != '0;
   assign rsp_ch.payload = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   // The input hold-off must keep the queue from ever running past its depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(FIFO_DEPTH))
      else $error("result queue count exceeds its depth");

   // A result never arrives at a full queue unless one leaves in that cycle.
   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < (PTR_W + 1)'(FIFO_DEPTH)) || pop)
      else $error("result pushed into a full queue");

   // A forwarded pixel must find the same column block's sum in stage 2.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> (s2_valid_ff && (s2_ctrl_ff.idx == s1_ctrl_ff.idx)))
      else $error("forwarded sum does not belong to the same column block");

   // A completing pixel reaches the queue after passing through stages 1 and 2.
   assert property (@(posedge clock) disable iff (reset)
      (accept && cur_ctrl.emit) |-> ##2 push)
      else $error("completed block did not reach the result queue");
`endif

endmodule
